// ----- hdl/slc_pkg.sv -----
// Shared constants, types and codes for the shelf load cell item counter.
// Used by the divider, the slot bank and the top level; depends on nothing.
package slc_pkg;

    localparam int NumSlots = 8;
    localparam int RawBits  = 24;
    localparam int SlotInW  = 3;
    localparam int SlotW    = $clog2(NumSlots);
    localparam int CntW     = 24;
    localparam int DivW     = RawBits + 1;
    localparam int StepW    = $clog2(DivW + 1);
    localparam int GramsW   = 21;
    localparam int OpW      = 2;
    localparam int KnownW   = 10;
    localparam int StatusW  = 2;
    localparam int RpgW     = 8;

    localparam logic [RpgW-1:0] RpgReset = RpgW'(22);
    localparam logic [CntW-1:0] CntMax   = '1;
    localparam logic [DivW-1:0] GramsPosLimit = DivW'((1 << (GramsW - 1)) - 1);
    localparam logic [DivW-1:0] GramsNegLimit = DivW'(1 << (GramsW - 1));

    localparam logic [OpW-1:0] OP_READING = 2'd0;
    localparam logic [OpW-1:0] OP_TARE    = 2'd1;
    localparam logic [OpW-1:0] OP_UNIT    = 2'd2;

    localparam logic [StatusW-1:0] ST_OK     = 2'd0;
    localparam logic [StatusW-1:0] ST_REJECT = 2'd1;
    localparam logic [StatusW-1:0] ST_UNCAL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_START,
        S_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic               tare_we;
        logic               unit_we;
        logic               count_we;
        logic [SlotW-1:0]   slot;
        logic [RawBits-1:0] tare;
        logic [CntW-1:0]    unit;
        logic [CntW-1:0]    count;
    } bank_wr_t;

    typedef struct packed {
        logic [RawBits-1:0] tare;
        logic [CntW-1:0]    unit;
        logic [CntW-1:0]    count;
    } bank_rd_t;

endpackage

// ----- hdl/slc_divider.sv -----
// Restoring bit-serial unsigned divider, one quotient bit per clock.
// Depends on slc_pkg for the dividend, divisor and step counter widths.
module slc_divider
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [slc_pkg::DivW-1:0]    dividend,
    input  logic [slc_pkg::CntW-1:0]    divisor,
    output logic                        busy,
    output logic [slc_pkg::DivW-1:0]    quotient
);

    logic                         busy_reg;
    logic                         busy_next;
    logic [slc_pkg::StepW-1:0]    step_reg;
    logic [slc_pkg::StepW-1:0]    step_next;
    logic [slc_pkg::CntW-1:0]     rem_reg;
    logic [slc_pkg::CntW-1:0]     rem_next;
    logic [slc_pkg::DivW-1:0]     quo_reg;
    logic [slc_pkg::DivW-1:0]     quo_next;
    logic [slc_pkg::CntW-1:0]     dvs_reg;
    logic [slc_pkg::CntW-1:0]     dvs_next;
    logic [slc_pkg::CntW:0]       trial;
    logic [slc_pkg::CntW:0]       diff;
    logic                         take;

    assign trial = {rem_reg, quo_reg[slc_pkg::DivW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign take  = ~diff[slc_pkg::CntW];

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = slc_pkg::StepW'(slc_pkg::DivW);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = take ? diff[slc_pkg::CntW-1:0] : trial[slc_pkg::CntW-1:0];
            quo_next  = {quo_reg[slc_pkg::DivW-2:0], take};
            step_next = step_reg - slc_pkg::StepW'(1);
            if (step_reg == slc_pkg::StepW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/slc_slot_bank.sv -----
// Per-slot state: tare reading, per-item raw weight and item count, cleared at reset.
// Depends on slc_pkg for the read and write structs.
module slc_slot_bank
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [slc_pkg::SlotW-1:0]   rd_slot,
    input  slc_pkg::bank_wr_t           wr,
    output slc_pkg::bank_rd_t           rd
);

    logic [slc_pkg::RawBits-1:0] tare_reg  [slc_pkg::NumSlots];
    logic [slc_pkg::CntW-1:0]    unit_reg  [slc_pkg::NumSlots];
    logic [slc_pkg::CntW-1:0]    count_reg [slc_pkg::NumSlots];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < slc_pkg::NumSlots; i++)
            begin
                tare_reg[i]  <= '0;
                unit_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr.tare_we)
            begin
                tare_reg[wr.slot] <= wr.tare;
            end
            if (wr.unit_we)
            begin
                unit_reg[wr.slot] <= wr.unit;
            end
            if (wr.count_we)
            begin
                count_reg[wr.slot] <= wr.count;
            end
        end
    end

    assign rd.tare  = tare_reg[rd_slot];
    assign rd.unit  = unit_reg[rd_slot];
    assign rd.count = count_reg[rd_slot];

endmodule

// ----- hdl/shelf_load_cell_item_counter_top.sv -----
// Top level of the shelf load cell item counter: control, two dividers and the slot bank.
// Depends on slc_pkg, slc_divider and slc_slot_bank.
//
// One word is taken at a time. After acceptance the block forms the tared load, starts
// the dividers, runs 25 bit-serial divide steps, sees the dividers finish, and then
// writes the slot and the output register and returns to idle for the next word. The
// two 25-step bit-serial dividers run side by side for the count and the grams. A new
// word is accepted as soon as the block is idle, even while a result still waits in the
// output register; it is held at its final step until that result is taken.
module shelf_load_cell_item_counter_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [slc_pkg::RpgW-1:0]           cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [slc_pkg::OpW-1:0]            op,
    input  logic [slc_pkg::SlotInW-1:0]        slot,
    input  logic signed [slc_pkg::RawBits-1:0] raw,
    input  logic [slc_pkg::KnownW-1:0]         known_count,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [slc_pkg::CntW-1:0]           item_count,
    output logic signed [slc_pkg::GramsW-1:0]  approx_grams,
    output logic [slc_pkg::StatusW-1:0]        status,
    output logic                               restock_event,
    output logic [slc_pkg::CntW-1:0]           previous_count,
    output logic [slc_pkg::CntW-1:0]           unit_weight,
    output logic                               calibrated
);

    slc_pkg::state_t               state_reg;
    slc_pkg::state_t               state_next;
    logic [slc_pkg::RpgW-1:0]      rpg_reg;
    logic [slc_pkg::OpW-1:0]       op_reg;
    logic [slc_pkg::SlotInW-1:0]   slot_reg;
    logic [slc_pkg::RawBits-1:0]   raw_reg;
    logic [slc_pkg::KnownW-1:0]    known_reg;
    logic [slc_pkg::DivW-1:0]      load_reg;
    logic [slc_pkg::DivW-1:0]      load_next;

    logic                          out_valid_reg;
    logic [slc_pkg::CntW-1:0]      item_count_reg;
    logic [slc_pkg::CntW-1:0]      item_count_next;
    logic [slc_pkg::GramsW-1:0]    grams_reg;
    logic [slc_pkg::GramsW-1:0]    grams_next;
    logic [slc_pkg::StatusW-1:0]   status_reg;
    logic [slc_pkg::StatusW-1:0]   status_next;
    logic                          restock_reg;
    logic                          restock_next;
    logic [slc_pkg::CntW-1:0]      prev_reg;
    logic [slc_pkg::CntW-1:0]      prev_next;
    logic [slc_pkg::CntW-1:0]      unit_out_reg;
    logic [slc_pkg::CntW-1:0]      unit_out_next;
    logic                          out_load;

    slc_pkg::bank_wr_t             wr;
    slc_pkg::bank_rd_t             rd;

    logic                          div_start;
    logic                          cnt_busy;
    logic                          g_busy;
    logic [slc_pkg::DivW-1:0]      cnt_dividend;
    logic [slc_pkg::CntW-1:0]      cnt_divisor;
    logic [slc_pkg::DivW-1:0]      cnt_q;
    logic [slc_pkg::DivW-1:0]      g_dividend;
    logic [slc_pkg::CntW-1:0]      g_divisor;
    logic [slc_pkg::DivW-1:0]      g_q;

    logic                          accept;
    logic                          slot_ok;
    logic                          load_neg;
    logic [slc_pkg::DivW-1:0]      load_mag;
    logic [slc_pkg::DivW-1:0]      cnt_sum;
    logic [slc_pkg::CntW-1:0]      cnt_sat;
    logic [slc_pkg::GramsW-1:0]    grams_val;

    assign accept   = in_valid & in_ready;
    assign in_ready = (state_reg == slc_pkg::S_IDLE);
    assign slot_ok  = (32'(slot_reg) < slc_pkg::NumSlots);
    assign load_neg = load_reg[slc_pkg::DivW-1];
    assign load_mag = load_neg ? ('0 - load_reg) : load_reg;
    assign cnt_sum  = load_reg + {2'b00, rd.unit[slc_pkg::CntW-1:1]};
    assign cnt_sat  = cnt_q[slc_pkg::DivW-1] ? slc_pkg::CntMax : cnt_q[slc_pkg::CntW-1:0];

    always_comb
    begin
        if (op_reg == slc_pkg::OP_UNIT)
        begin
            cnt_dividend = load_reg;
            cnt_divisor  = (known_reg == '0) ? slc_pkg::CntW'(1)
                                             : slc_pkg::CntW'(known_reg);
        end
        else
        begin
            cnt_dividend = cnt_sum;
            cnt_divisor  = (rd.unit == '0) ? slc_pkg::CntW'(1) : rd.unit;
        end
        g_dividend = load_mag;
        g_divisor  = (rpg_reg == '0) ? slc_pkg::CntW'(1) : slc_pkg::CntW'(rpg_reg);
    end

    always_comb
    begin
        if (!load_neg && g_q > slc_pkg::GramsPosLimit)
        begin
            grams_val = slc_pkg::GramsPosLimit[slc_pkg::GramsW-1:0];
        end
        else if (load_neg && g_q > slc_pkg::GramsNegLimit)
        begin
            grams_val = slc_pkg::GramsNegLimit[slc_pkg::GramsW-1:0];
        end
        else if (load_neg)
        begin
            grams_val = '0 - g_q[slc_pkg::GramsW-1:0];
        end
        else
        begin
            grams_val = g_q[slc_pkg::GramsW-1:0];
        end
    end

    slc_divider u_cnt_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cnt_dividend),
        .divisor  (cnt_divisor),
        .busy     (cnt_busy),
        .quotient (cnt_q)
    );

    slc_divider u_grams_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (g_dividend),
        .divisor  (g_divisor),
        .busy     (g_busy),
        .quotient (g_q)
    );

    slc_slot_bank u_bank
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_slot (slot_reg[slc_pkg::SlotW-1:0]),
        .wr      (wr),
        .rd      (rd)
    );

    always_comb
    begin
        state_next      = state_reg;
        load_next       = load_reg;
        div_start       = 1'b0;
        out_load        = 1'b0;
        wr              = '0;
        wr.slot         = slot_reg[slc_pkg::SlotW-1:0];
        wr.tare         = raw_reg;
        wr.unit         = cnt_sat;
        wr.count        = rd.count;
        status_next     = slc_pkg::ST_OK;
        restock_next    = 1'b0;
        grams_next      = '0;
        prev_next       = rd.count;
        item_count_next = rd.count;
        unit_out_next   = rd.unit;
        unique case (state_reg)
            slc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = slc_pkg::S_LOAD;
                end
            end
            slc_pkg::S_LOAD:
            begin
                load_next  = {raw_reg[slc_pkg::RawBits-1], raw_reg}
                           - {rd.tare[slc_pkg::RawBits-1], rd.tare};
                state_next = slc_pkg::S_START;
            end
            slc_pkg::S_START:
            begin
                div_start  = 1'b1;
                state_next = slc_pkg::S_WAIT;
            end
            slc_pkg::S_WAIT:
            begin
                if (!cnt_busy && !g_busy)
                begin
                    state_next = slc_pkg::S_FINISH;
                end
            end
            slc_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = slc_pkg::S_IDLE;
                    if (!slot_ok)
                    begin
                        status_next   = slc_pkg::ST_REJECT;
                        prev_next     = '0;
                        unit_out_next = '0;
                    end
                    else
                    begin
                        unique case (op_reg)
                            slc_pkg::OP_READING:
                            begin
                                grams_next = grams_val;
                                if (rd.unit != '0)
                                begin
                                    wr.count_we  = 1'b1;
                                    wr.count     = load_neg ? '0 : cnt_sat;
                                    restock_next = (wr.count != rd.count);
                                end
                                else
                                begin
                                    status_next = slc_pkg::ST_UNCAL;
                                end
                            end
                            slc_pkg::OP_TARE:
                            begin
                                wr.tare_we = 1'b1;
                            end
                            slc_pkg::OP_UNIT:
                            begin
                                if (known_reg == '0 || load_neg || load_reg == '0)
                                begin
                                    status_next = slc_pkg::ST_REJECT;
                                end
                                else
                                begin
                                    wr.unit_we    = 1'b1;
                                    wr.count_we   = 1'b1;
                                    wr.count      = slc_pkg::CntW'(known_reg);
                                    unit_out_next = cnt_sat;
                                end
                            end
                            default:
                            begin
                                status_next = slc_pkg::ST_REJECT;
                            end
                        endcase
                    end
                    item_count_next = slot_ok ? wr.count : '0;
                end
            end
            default:
            begin
                state_next = slc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slc_pkg::S_IDLE;
            rpg_reg       <= slc_pkg::RpgReset;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                rpg_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            slot_reg  <= slot;
            raw_reg   <= raw;
            known_reg <= known_count;
        end
        load_reg <= load_next;
        if (out_load)
        begin
            item_count_reg <= item_count_next;
            grams_reg      <= grams_next;
            status_reg     <= status_next;
            restock_reg    <= restock_next;
            prev_reg       <= prev_next;
            unit_out_reg   <= unit_out_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign item_count     = item_count_reg;
    assign approx_grams   = grams_reg;
    assign status         = status_reg;
    assign restock_event  = restock_reg;
    assign previous_count = prev_reg;
    assign unit_weight    = unit_out_reg;
    assign calibrated     = (unit_out_reg != '0);

    a_restock_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && restock_event |-> status == slc_pkg::ST_OK)
        else $error("Restock event flagged on a word that was not a good reading.");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_busy == g_busy)
        else $error("The count and grams dividers lost step.");

    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == slc_pkg::S_LOAD)
        else $error("An accepted word did not start its load step.");

    a_uncal_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == slc_pkg::ST_UNCAL |-> !calibrated && !restock_event)
        else $error("Uncalibrated reading reported a calibrated slot or a restock.");

endmodule

// ----- verif/shelf_load_cell_item_counter_top_tb.sv -----
// Self-checking testbench for the shelf load cell item counter top level.
// Depends on slc_pkg and shelf_load_cell_item_counter_top; it predicts every result
// word itself and drives both handshakes with random idle cycles, but for one random traffic run that has none.
`timescale 1ns / 100ps

module shelf_load_cell_item_counter_top_tb;

    import slc_pkg::*;

    localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
    localparam longint GramsHigh = (longint'(1) << (GramsW - 1)) - 1;
    localparam longint GramsLow  = -(longint'(1) << (GramsW - 1));
    localparam longint RawHigh   = (longint'(1) << (RawBits - 1)) - 1;
    localparam longint RawLow    = -(longint'(1) << (RawBits - 1));

    typedef struct {
        logic [CntW-1:0]           item_count;
        logic signed [GramsW-1:0]  grams;
        logic [StatusW-1:0]        status;
        logic                      restock;
        logic [CntW-1:0]           prev;
        logic [CntW-1:0]           unit;
        logic                      cal;
    } slot_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [RpgW-1:0]           cfg_wdata;
    logic                      in_valid;
    logic                      in_ready;
    logic [OpW-1:0]            op;
    logic [SlotInW-1:0]        slot;
    logic signed [RawBits-1:0] raw;
    logic [KnownW-1:0]         known_count;
    logic                      out_valid;
    logic                      out_ready;
    logic [CntW-1:0]           item_count;
    logic signed [GramsW-1:0]  approx_grams;
    logic [StatusW-1:0]        status;
    logic                      restock_event;
    logic [CntW-1:0]           previous_count;
    logic [CntW-1:0]           unit_weight;
    logic                      calibrated;

    logic [RpgW-1:0]           scale_rpg;
    logic signed [RawBits-1:0] shelf_tare [NumSlots];
    logic [CntW-1:0]           shelf_unit [NumSlots];
    logic [CntW-1:0]           shelf_count [NumSlots];
    logic signed [RawBits-1:0] shelf_last [NumSlots];

    slot_result_t expected_results[$];
    bit idle_gaps;
    int failures;
    int words_sent;
    int readings_sent;
    int calibrations_sent;
    int restocks_seen;
    int rejects_seen;
    int settings_used;

    shelf_load_cell_item_counter_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .slot           (slot),
        .raw            (raw),
        .known_count    (known_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .item_count     (item_count),
        .approx_grams   (approx_grams),
        .status         (status),
        .restock_event  (restock_event),
        .previous_count (previous_count),
        .unit_weight    (unit_weight),
        .calibrated     (calibrated)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic slot_result_t predict_slot_step(input logic [OpW-1:0] f_op,
                                                       input logic [SlotInW-1:0] f_slot,
                                                       input logic signed [RawBits-1:0] f_raw,
                                                       input logic [KnownW-1:0] f_known);
        slot_result_t r;
        longint load;
        longint per_gram;
        longint unit_l;
        longint grams;
        longint fresh;
        r.item_count = '0;
        r.grams = '0;
        r.status = ST_OK;
        r.restock = 1'b0;
        r.prev = '0;
        r.unit = '0;
        r.cal = 1'b0;
        if (int'(f_slot) >= NumSlots)
        begin
            r.status = ST_REJECT;
            return r;
        end
        load = longint'(f_raw) - longint'(shelf_tare[f_slot]);
        r.prev = shelf_count[f_slot];
        case (f_op)
            OP_READING:
            begin
                shelf_last[f_slot] = f_raw;
                if (shelf_unit[f_slot] != '0)
                begin
                    unit_l = longint'(shelf_unit[f_slot]);
                    fresh = (load >= 0) ? (load + unit_l / 2) / unit_l : 0;
                    if (fresh > longint'(CntMax))
                        fresh = longint'(CntMax);
                    r.restock = (fresh != longint'(r.prev));
                    shelf_count[f_slot] = fresh[CntW-1:0];
                end
                else
                begin
                    r.status = ST_UNCAL;
                end
                per_gram = (scale_rpg == '0) ? 1 : longint'(scale_rpg);
                grams = load / per_gram;
                if (grams > GramsHigh)
                    grams = GramsHigh;
                if (grams < GramsLow)
                    grams = GramsLow;
                r.grams = grams[GramsW-1:0];
            end
            OP_TARE:
            begin
                shelf_tare[f_slot] = f_raw;
            end
            OP_UNIT:
            begin
                if (f_known == '0 || load <= 0)
                begin
                    r.status = ST_REJECT;
                end
                else
                begin
                    unit_l = load / longint'(f_known);
                    if (unit_l > longint'(CntMax))
                        unit_l = longint'(CntMax);
                    shelf_unit[f_slot] = unit_l[CntW-1:0];
                    shelf_count[f_slot] = CntW'(f_known);
                end
            end
            default:
            begin
                r.status = ST_REJECT;
            end
        endcase
        r.item_count = shelf_count[f_slot];
        r.unit = shelf_unit[f_slot];
        r.cal = (shelf_unit[f_slot] != '0);
        return r;
    endfunction

    function automatic logic signed [RawBits-1:0] clamp_raw(input longint v);
        if (v > RawHigh)
            v = RawHigh;
        if (v < RawLow)
            v = RawLow;
        return v[RawBits-1:0];
    endfunction

    function automatic void check_field(input string name, input longint want_v,
                                        input longint got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, actual %0d", name, want_v, got_v);
            failures++;
        end
    endfunction

    task automatic send_word(input logic [OpW-1:0] w_op, input logic [SlotInW-1:0] w_slot,
                             input logic signed [RawBits-1:0] w_raw,
                             input logic [KnownW-1:0] w_known);
        int gap;
        slot_result_t want;
        gap = idle_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= w_op;
        slot <= w_slot;
        raw <= w_raw;
        known_count <= w_known;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = predict_slot_step(w_op, w_slot, w_raw, w_known);
        expected_results.push_back(want);
        words_sent++;
        if (w_op == OP_READING)
            readings_sent++;
        if (w_op == OP_TARE || w_op == OP_UNIT)
            calibrations_sent++;
        if (want.restock)
            restocks_seen++;
        if (want.status == ST_REJECT)
            rejects_seen++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic set_scale(input logic [RpgW-1:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        scale_rpg = v;
        settings_used++;
    endtask

    task automatic test_uncalibrated_readings();
        send_word(OP_READING, 3'd0, 24'sd8388607, 10'd0);
        send_word(OP_READING, 3'd1, -24'sd8388608, 10'd1023);
        send_word(OP_READING, 3'd2, 24'sd0, 10'd0);
    endtask

    task automatic test_tare_calibration();
        send_word(OP_TARE, 3'd0, 24'sd1000, 10'd0);
        send_word(OP_TARE, 3'd7, -24'sd8388608, 10'd0);
        send_word(OP_TARE, 3'd6, 24'sd8388607, 10'd0);
    endtask

    task automatic test_unit_calibration();
        send_word(OP_UNIT, 3'd0, 24'sd5000, 10'd0);
        send_word(OP_UNIT, 3'd0, 24'sd1000, 10'd10);
        send_word(OP_UNIT, 3'd0, 24'sd900, 10'd10);
        send_word(OP_UNIT, 3'd0, 24'sd1010, 10'd20);
        send_word(OP_UNIT, 3'd0, 24'sd3500, 10'd10);
        send_word(OP_UNIT, 3'd7, -24'sd8388603, 10'd5);
        send_word(OP_UNIT, 3'd3, 24'sd8388607, 10'd1023);
    endtask

    task automatic test_calibrated_readings();
        send_word(OP_READING, 3'd0, 24'sd3500, 10'd0);
        send_word(OP_READING, 3'd0, 24'sd3624, 10'd0);
        send_word(OP_READING, 3'd0, 24'sd3625, 10'd0);
        send_word(OP_READING, 3'd0, 24'sd900, 10'd0);
        send_word(OP_READING, 3'd3, -24'sd5, 10'd0);
    endtask

    task automatic test_unused_op();
        send_word(OP_UNUSED, 3'd0, 24'sd1234, 10'd5);
        send_word(OP_UNUSED, 3'd3, -24'sd1, 10'd1023);
    endtask

    task automatic test_saturation();
        set_scale(8'd1);
        send_word(OP_READING, 3'd7, 24'sd8388607, 10'd0);
        send_word(OP_READING, 3'd6, -24'sd8388608, 10'd0);
        set_scale(8'd0);
        send_word(OP_READING, 3'd6, -24'sd8388608, 10'd0);
        set_scale(8'd255);
        send_word(OP_READING, 3'd7, 24'sd8388607, 10'd0);
    endtask

    task automatic test_random_traffic(input int n_words);
        int sel;
        logic [SlotInW-1:0] s;
        logic [KnownW-1:0] k;
        longint u;
        longint base;
        longint n;
        for (int i = 0; i < n_words; i++)
        begin
            sel = $urandom_range(0, 99);
            s = SlotInW'($urandom_range(0, NumSlots - 1));
            k = KnownW'($urandom_range(0, 1023));
            base = longint'(shelf_tare[s]);
            u = longint'(shelf_unit[s]);
            if (sel < 55)
            begin
                if ($urandom_range(0, 2) == 0)
                    n = longint'(shelf_count[s]);
                else
                    n = longint'($urandom_range(0, 300));
                send_word(OP_READING, s, clamp_raw(base + n * u
                          + longint'($urandom_range(0, 32'(u + 1000)))
                          - (u + 1000) / 2), k);
            end
            else if (sel < 65)
            begin
                send_word(OP_READING, s, RawBits'($urandom()), k);
            end
            else if (sel < 75)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_word(OP_TARE, s, RawBits'($urandom()), k);
                else
                    send_word(OP_TARE, s,
                              clamp_raw(longint'($urandom_range(0, 20000)) - 10000), k);
            end
            else if (sel < 92)
            begin
                k = KnownW'($urandom_range(1, 1023));
                n = longint'(k) * longint'($urandom_range(0, 3000))
                    + longint'($urandom_range(0, 32'(k) - 1));
                send_word(OP_UNIT, s, clamp_raw(base + n), k);
            end
            else if (sel < 96)
            begin
                if ($urandom_range(0, 1) == 0)
                    k = '0;
                send_word(OP_UNIT, s, RawBits'($urandom()), k);
            end
            else
            begin
                send_word(OP_UNUSED, s, RawBits'($urandom()), k);
            end
        end
    endtask

    initial
    begin : result_checker
        slot_result_t want;
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = idle_gaps ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (expected_results.size() == 0)
            begin
                $error("result word with no expectation pending");
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("item_count", longint'(want.item_count), longint'(item_count));
                check_field("approx_grams", longint'(want.grams), longint'(approx_grams));
                check_field("status", longint'(want.status), longint'(status));
                check_field("restock_event", longint'(want.restock),
                            longint'(restock_event));
                check_field("previous_count", longint'(want.prev),
                            longint'(previous_count));
                check_field("unit_weight", longint'(want.unit), longint'(unit_weight));
                check_field("calibrated", longint'(want.cal), longint'(calibrated));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        op = '0;
        slot = '0;
        raw = '0;
        known_count = '0;
        out_ready = 1'b0;
        idle_gaps = 1'b1;
        scale_rpg = RpgReset;
        for (int i = 0; i < NumSlots; i++)
        begin
            shelf_tare[i] = '0;
            shelf_unit[i] = '0;
            shelf_count[i] = '0;
            shelf_last[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_uncalibrated_readings();
        test_tare_calibration();
        test_unit_calibration();
        test_calibrated_readings();
        test_unused_op();
        test_saturation();

        set_scale(8'd0);
        test_random_traffic(100);
        set_scale(8'd255);
        idle_gaps = 1'b0;
        test_random_traffic(100);
        idle_gaps = 1'b1;
        set_scale(8'd1);
        test_random_traffic(100);
        set_scale(RpgW'($urandom_range(2, 254)));
        test_random_traffic(100);
        set_scale(RpgReset);
        test_random_traffic(100);

        wait_idle();
        repeat (40) @(posedge clk);
        $display("Checked %0d result words: %0d readings and %0d calibrations over %0d scales.",
                 words_sent, readings_sent, calibrations_sent, settings_used + 1);
        $display("The run held %0d restock events and %0d rejected words.",
                 restocks_seen, rejects_seen);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
